// ===== design/wiegand_card_access_controller_core_defines.svh =====
// Assertion macros shared by the checker.
`ifndef WIEGAND_CARD_ACCESS_CONTROLLER_CORE_DEFINES_SVH
`define WIEGAND_CARD_ACCESS_CONTROLLER_CORE_DEFINES_SVH

// An implication checked on every rising clock edge outside reset.
`define WCAC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequence is checked in the cycle after the antecedent.
`define WCAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wcac_pkg.sv =====
package wcac_pkg;

  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned FrameBits = 26;
  localparam int unsigned IdW = 24;

  localparam logic [2:0] ReqBit    = 3'd0;
  localparam logic [2:0] ReqTick   = 3'd1;
  localparam logic [2:0] ReqButton = 3'd2;
  localparam logic [2:0] ReqEnroll = 3'd3;
  localparam logic [2:0] ReqWipe   = 3'd4;

  localparam logic [3:0] EvNone     = 4'd0;
  localparam logic [3:0] EvBit      = 4'd1;
  localparam logic [3:0] EvShort    = 4'd2;
  localparam logic [3:0] EvGranted  = 4'd3;
  localparam logic [3:0] EvDenied   = 4'd4;
  localparam logic [3:0] EvEnrolled = 4'd5;
  localparam logic [3:0] EvMaster   = 4'd6;
  localparam logic [3:0] EvAdded    = 4'd7;
  localparam logic [3:0] EvRemoved  = 4'd8;
  localparam logic [3:0] EvFull     = 4'd9;
  localparam logic [3:0] EvButton   = 4'd10;

  localparam logic [1:0] CfgDoor   = 2'd0;
  localparam logic [1:0] CfgWindow = 2'd1;
  localparam logic [1:0] CfgGap    = 2'd2;

  localparam logic [15:0] DoorReset   = 16'd1000;
  localparam logic [15:0] WindowReset = 16'd3000;
  localparam logic [7:0]  GapReset    = 8'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clr_start;   // begin table wipe / clear pass
    logic       tick;        // advance master and relay timers
    logic       take_bit;    // accept a wiegand bit
    logic       button;      // door button
    logic       enroll;      // set enroll pending
    logic       close_ch;    // advance gap counter of channel sel
    logic       ch_sel;
    logic       search_start;
    logic       search_step;
    logic       resolve;     // apply frame decision
    logic       end_tick;    // master window check at end of tick
  } cmd_t;

  typedef struct packed {
    logic       clr_busy;
    logic       close_due;   // selected channel's gap reached
    logic       frame_bits;  // selected channel has bits
    logic       frame_full;  // frame complete, needs a search
    logic       search_done;
    logic       bit_room;    // incoming reader's frame still takes a bit
  } stat_t;

endpackage

// ===== design/wcac_ram.sv =====
module wcac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/wcac_datapath.sv =====
module wcac_datapath import wcac_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             in_reader,
  input  logic             in_bit,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [15:0]      cfg_data,
  output stat_t            stat,
  output logic [3:0]       frame_ev,
  output logic [IdW-1:0]   frame_id,
  output logic             relay,
  output logic             mmode
);
  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = $clog2(FrameBits + 1);

  logic [15:0] door_ticks, window_ticks;
  logic [7:0]  gap_ticks;
  logic [FrameBits-1:0] buffer [2];
  logic [CW-1:0] count [2];
  logic [7:0] gap [2];
  logic [PW-1:0] append_index;
  logic [IdW-1:0] master_id;
  logic enroll_pending, master_flag;
  logic [15:0] master_timer, relay_timer;
  logic [PW-1:0] clr_ptr;
  logic clearing;
  logic [PW-1:0] search_ptr;
  logic search_hit, search_run;
  logic [AW-1:0] hit_index;
  logic [IdW-1:0] cur_id;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [IdW:0] ram_wdata, ram_rdata;

  wcac_ram #(.Width(IdW + 1), .Depth(TableDepth)) u_table (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic sel;
  logic [7:0] gap_inc;
  assign sel = cmd.ch_sel;
  assign gap_inc = gap[sel] + 8'd1;
  assign cur_id = buffer[sel][IdW:1];
  assign ram_raddr = search_ptr[AW-1:0];

  // The read of address search_ptr arrives in the next cycle and is compared then.
  logic cmp_valid;
  logic [PW-1:0] cmp_ptr;

  always_comb begin
    stat.clr_busy    = clearing;
    stat.close_due   = (gap[sel] == gap_ticks);
    stat.frame_bits  = (count[sel] != '0);
    stat.frame_full  = (count[sel] >= CW'(FrameBits));
    stat.search_done = !search_run && !cmp_valid;
    stat.bit_room    = (count[in_reader] < CW'(FrameBits));
  end

  logic [3:0] dec_ev;
  always_comb begin
    if (count[sel] < CW'(FrameBits)) begin
      dec_ev = EvShort;
    end else if (enroll_pending) begin
      dec_ev = EvEnrolled;
    end else if (cur_id == master_id) begin
      dec_ev = EvMaster;
    end else if (master_flag) begin
      if (search_hit) begin
        dec_ev = EvRemoved;
      end else if (append_index >= PW'(TableDepth)) begin
        dec_ev = EvFull;
      end else begin
        dec_ev = EvAdded;
      end
    end else if (search_hit) begin
      dec_ev = EvGranted;
    end else begin
      dec_ev = EvDenied;
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = hit_index;
    ram_wdata = '0;
    if (clearing) begin
      ram_we = 1'b1;
      ram_waddr = clr_ptr[AW-1:0];
    end else if (cmd.resolve && stat.frame_bits && dec_ev == EvRemoved) begin
      ram_we = 1'b1;
    end else if (cmd.resolve && stat.frame_bits && dec_ev == EvAdded) begin
      ram_we = 1'b1;
      ram_waddr = append_index[AW-1:0];
      ram_wdata = {1'b1, cur_id};
    end
  end

  logic relay_on_q;
  assign relay = relay_on_q;
  assign mmode = master_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      door_ticks <= DoorReset;
      window_ticks <= WindowReset;
      gap_ticks <= GapReset;
      for (int c = 0; c < 2; c++) begin
        buffer[c] <= '0;
        count[c] <= '0;
        gap[c] <= '0;
      end
      append_index <= '0;
      master_id <= '0;
      enroll_pending <= 1'b1;
      master_flag <= 1'b0;
      master_timer <= '0;
      relay_timer <= DoorReset;
      relay_on_q <= 1'b0;
      clearing <= 1'b0;
      clr_ptr <= '0;
      search_run <= 1'b0;
      search_ptr <= '0;
      search_hit <= 1'b0;
      hit_index <= '0;
      cmp_valid <= 1'b0;
      cmp_ptr <= '0;
      frame_ev <= EvNone;
      frame_id <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CfgDoor:   door_ticks <= cfg_data;
          CfgWindow: window_ticks <= cfg_data;
          CfgGap:    gap_ticks <= cfg_data[7:0];
          default:   ;
        endcase
      end
      if (cmd.clr_start) begin
        clearing <= 1'b1;
        clr_ptr <= '0;
        append_index <= '0;
      end else if (clearing) begin
        clr_ptr <= clr_ptr + PW'(1);
        if (clr_ptr == PW'(TableDepth - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (cmd.take_bit) begin
        gap[in_reader] <= '0;
        if (count[in_reader] < CW'(FrameBits)) begin
          buffer[in_reader][count[in_reader]] <= in_bit;
          count[in_reader] <= count[in_reader] + CW'(1);
        end
      end
      if (cmd.button) begin
        relay_timer <= '0;
        relay_on_q <= 1'b1;
      end
      if (cmd.enroll) begin
        enroll_pending <= 1'b1;
      end
      if (cmd.tick) begin
        if (master_timer != 16'hFFFF) master_timer <= master_timer + 16'd1;
        if (relay_timer != 16'hFFFF) relay_timer <= relay_timer + 16'd1;
        if (((relay_timer == 16'hFFFF) ? relay_timer : relay_timer + 16'd1)
            >= door_ticks) begin
          relay_on_q <= 1'b0;
        end
      end
      // Gap counters advance channel by channel as the controller visits them.
      if (cmd.close_ch) begin
        gap[sel] <= gap_inc;
      end
      if (cmd.search_start) begin
        search_run <= 1'b1;
        search_ptr <= '0;
        search_hit <= 1'b0;
        cmp_valid <= 1'b0;
      end else begin
        cmp_valid <= search_run;
        cmp_ptr <= search_ptr;
        if (search_run) begin
          if (search_ptr + PW'(1) >= append_index ||
              search_ptr == PW'(TableDepth - 1)) begin
            search_run <= 1'b0;
          end
          search_ptr <= search_ptr + PW'(1);
        end
        // Entries at or past the append pointer never count, written or not.
        if (cmp_valid && !search_hit && cmp_ptr < append_index &&
            ram_rdata == {1'b1, cur_id}) begin
          search_hit <= 1'b1;
          hit_index <= cmp_ptr[AW-1:0];
          search_run <= 1'b0;
        end
        if (cmd.search_step && append_index == '0) begin
          search_run <= 1'b0;
        end
      end
      if (cmd.resolve) begin
        buffer[sel] <= '0;
        count[sel] <= '0;
        gap[sel] <= '0;
        frame_ev <= stat.frame_bits ? dec_ev : EvNone;
        frame_id <= (stat.frame_bits && stat.frame_full) ? cur_id : '0;
        if (stat.frame_bits && stat.frame_full) begin
          unique case (dec_ev)
            EvEnrolled: begin
              master_id <= cur_id;
              enroll_pending <= 1'b0;
              master_flag <= 1'b1;
              master_timer <= '0;
            end
            EvMaster, EvRemoved, EvFull: begin
              master_flag <= 1'b1;
              master_timer <= '0;
            end
            EvAdded: begin
              master_timer <= '0;
              append_index <= append_index + PW'(1);
              relay_timer <= '0;
              relay_on_q <= 1'b1;
            end
            EvGranted: begin
              relay_timer <= '0;
              relay_on_q <= 1'b1;
            end
            default: ;
          endcase
        end
      end
      if (cmd.end_tick && master_flag && master_timer >= window_ticks) begin
        master_flag <= 1'b0;
      end
    end
  end
endmodule

// ===== design/wcac_ctrl.sv =====
module wcac_ctrl import wcac_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [2:0]     in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [3:0]     out_ev,
  output logic [IdW-1:0] out_id,
  output logic           out_last,
  output cmd_t           cmd,
  input  stat_t          stat,
  input  logic [3:0]     frame_ev,
  input  logic [IdW-1:0] frame_id
);
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_GAP    = 8'b0000_0010,
    S_SEARCH = 8'b0000_0100,
    S_WAIT   = 8'b0000_1000,
    S_RES    = 8'b0001_0000,
    S_EMIT   = 8'b0010_0000,
    S_END    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic ch, emitted;
  logic [3:0] res_ev;
  logic [IdW-1:0] res_id;
  logic res_last;

  assign in_stall = (state != S_IDLE) || stat.clr_busy;
  assign out_valid = (state == S_OUT);
  assign out_ev = res_ev;
  assign out_id = res_id;
  assign out_last = res_last;

  logic accept;
  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.ch_sel = ch;
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) begin
        unique case (in_req)
          ReqBit: cmd.take_bit = 1'b1;
          ReqTick: cmd.tick = 1'b1;
          ReqButton: cmd.button = 1'b1;
          ReqEnroll: cmd.enroll = 1'b1;
          ReqWipe: cmd.clr_start = 1'b1;
          default: ;
        endcase
        state_next = (in_req == ReqTick) ? S_GAP : S_OUT;
      end
      S_GAP: begin
        cmd.close_ch = 1'b1;
        if ((stat.close_due ? 1'b0 : 1'b1) == 1'b1) begin
          state_next = S_WAIT;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        // Gap counter was advanced; equality with the gap setting closes the frame.
        if (stat.close_due && stat.frame_full) begin
          cmd.search_start = 1'b1;
          state_next = S_SEARCH;
        end else if (stat.close_due) begin
          state_next = S_RES;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (stat.search_done) state_next = S_RES;
      end
      S_RES: begin
        cmd.resolve = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        state_next = S_END;
      end
      S_END: begin
        if (ch == 1'b0) begin
          state_next = S_GAP;
        end else begin
          cmd.end_tick = 1'b1;
          state_next = S_OUT;
        end
      end
      // A tick with two results stays here for the second transaction.
      S_OUT: if (!out_stall) state_next = emitted ? S_OUT : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Pending frame result, held until channel 1 decides on last.
  logic hold_v;
  logic [3:0] hold_ev;
  logic [IdW-1:0] hold_id;
  logic close_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch <= 1'b0;
      emitted <= 1'b0;
      hold_v <= 1'b0;
      close_seen <= 1'b0;
      res_ev <= EvNone;
      res_id <= '0;
      res_last <= 1'b0;
      hold_ev <= EvNone;
      hold_id <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (accept) begin
          ch <= 1'b0;
          emitted <= 1'b0;
          hold_v <= 1'b0;
          close_seen <= 1'b0;
          res_last <= 1'b1;
          res_id <= '0;
          res_ev <= (in_req == ReqBit) ? (stat.bit_room ? EvBit : EvNone) :
                    (in_req == ReqButton) ? EvButton : EvNone;
        end
        S_WAIT: close_seen <= stat.close_due;
        S_EMIT: begin
          if (close_seen && frame_ev != EvNone) begin
            if (ch == 1'b0) begin
              hold_v <= 1'b1;
              hold_ev <= frame_ev;
              hold_id <= frame_id;
            end else if (hold_v) begin
              res_ev <= hold_ev;
              res_id <= hold_id;
              res_last <= 1'b0;
              hold_ev <= frame_ev;
              hold_id <= frame_id;
              emitted <= 1'b1;
            end else begin
              hold_v <= 1'b1;
              hold_ev <= frame_ev;
              hold_id <= frame_id;
            end
          end
        end
        S_END: begin
          ch <= 1'b1;
          if (ch == 1'b1) begin
            if (emitted) begin
              res_last <= 1'b0;
            end else if (hold_v) begin
              res_ev <= hold_ev;
              res_id <= hold_id;
              res_last <= 1'b1;
              hold_v <= 1'b0;
            end
          end
        end
        S_OUT: if (!out_stall && emitted) begin
          // Second result of the tick goes out next.
          res_ev <= hold_ev;
          res_id <= hold_id;
          res_last <= 1'b1;
          emitted <= 1'b0;
          hold_v <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== design/wiegand_card_access_controller_core.sv =====
// A bit, button, enroll or wipe request gives its result in the cycle after
// acceptance. A tick visits channel 0, then 1, each through the gap and wait
// states, a table search for a complete closing frame, a resolve state for a
// closing frame, then the emit and end states; a second result follows once
// the first is taken. One transaction at a time. Synchronous reset; a wipe
// clears the table while input stalls. No table clearing after reset.
module wiegand_card_access_controller_core import wcac_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       req_type,
  input  logic             reader,
  input  logic             bit_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       event_res,
  output logic [IdW-1:0]   card_id,
  output logic             relay_on,
  output logic             master_mode,
  output logic             last,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  cmd_t cmd;
  stat_t stat;
  logic [3:0] frame_ev;
  logic [IdW-1:0] frame_id;

  wcac_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_req(req_type), .out_valid(out_valid), .out_stall(out_stall),
    .out_ev(event_res), .out_id(card_id), .out_last(last),
    .cmd(cmd), .stat(stat), .frame_ev(frame_ev), .frame_id(frame_id)
  );

  wcac_datapath #(.TableDepth(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_reader(reader), .in_bit(bit_value),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data), .stat(stat),
    .frame_ev(frame_ev), .frame_id(frame_id), .relay(relay_on),
    .mmode(master_mode)
  );
endmodule

// ===== design/wcac_checker.sv =====
`include "wiegand_card_access_controller_core_defines.svh"
module wcac_checker import wcac_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] event_res,
  input logic [23:0] card_id
);
  `WCAC_ASSERT_IMPL(a_no_accept_while_out, out_valid && in_valid, in_stall,
    "input taken during output")
  `WCAC_ASSERT_IMPL(a_short_no_id, out_valid && event_res == EvShort, card_id == '0,
    "short frame carries an id")
  `WCAC_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid, "output dropped")
endmodule

bind wiegand_card_access_controller_core wcac_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .event_res(event_res),
  .card_id(card_id)
);
